// ----- rtl/bpc_pkg.sv -----
// Shared types and constants for the button press classifier.
package bpc_pkg;

  // Configuration register width and port index width
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD   = 2'd2;

  // Register values after reset
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd40;
  localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd1500;
  localparam logic [CFG_W-1:0] LONG_HOLD_RST   = 16'd5000;

  // Default width of the debounce and hold counters
  localparam int COUNT_BITS_DEF = 16;

  // One tick item
  typedef struct packed {
    logic raw_level;
    logic take_short;
    logic take_long;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic stable_level;
    logic press_taken;
    logic long_press_taken;
    logic short_waiting;
    logic long_waiting;
  } out_item_t;

  // Current register settings
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] short_limit_ticks;
    logic [CFG_W-1:0] long_hold_ticks;
  } cfg_regs_t;

endpackage

// ----- rtl/button_press_classifier.sv -----
// Top level of the button press classifier: item registers around the core.
//
// Each tick item is taken into an input register; its debounce and hold
// update is then done in a single pass and the result lands in a result
// register once that register is free or draining: one item per cycle
// while out_stall is low. The counter and flag update between those two
// registers sets the rate. While a result waits, the input register still
// takes one more item; in_stall rises only when both registers are full and
// out_stall is high. Configuration writes land at once and are meant for
// idle periods only.
module button_press_classifier #(
  parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bpc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bpc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]      cfg_data
);
  import bpc_pkg::*;

  cfg_regs_t  regs;
  in_item_t   in_item_r;
  logic       in_v_r;
  out_item_t  result;
  out_item_t  out_item_r;
  logic       out_v_r;
  logic       adv;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  bpc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (in_item_r),
    .regs   (regs),
    .result (result)
  );

  // Move the held item on when the result register is free or draining
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

endmodule

// ----- rtl/bpc_cfg.sv -----
// Configuration register file for the button press classifier.
module bpc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]      cfg_data,
  output bpc_pkg::cfg_regs_t             regs
);
  import bpc_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:    regs_nxt.debounce_ticks    = cfg_data;
        REG_SHORT_LIMIT: regs_nxt.short_limit_ticks = cfg_data;
        REG_LONG_HOLD:   regs_nxt.long_hold_ticks   = cfg_data;
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.debounce_ticks    <= DEBOUNCE_RST;
      regs_r.short_limit_ticks <= SHORT_LIMIT_RST;
      regs_r.long_hold_ticks   <= LONG_HOLD_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ----- rtl/bpc_core.sv -----
// Debounce, hold timing and press flag state with its one-pass update.
module bpc_core #(
  parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  bpc_pkg::in_item_t   item,
  input  bpc_pkg::cfg_regs_t  regs,
  output bpc_pkg::out_item_t  result
);
  import bpc_pkg::*;

  // Compare width wide enough for both counters and registers
  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic                  stable_r,        stable_nxt;
  logic                  change_active_r, change_active_nxt;
  logic [COUNT_BITS-1:0] change_elapsed_r, change_elapsed_nxt;
  logic                  press_seen_r,    press_seen_nxt;
  logic [COUNT_BITS-1:0] held_r,          held_nxt;
  logic                  long_done_r,     long_done_nxt;
  logic                  short_flag_r,    short_flag_nxt;
  logic                  long_flag_r,     long_flag_nxt;

  logic [COUNT_BITS-1:0] change_inc;
  logic                  got_short;
  logic                  got_long;

  // Saturating increment of the change counter
  assign change_inc = (change_elapsed_r == '1) ? change_elapsed_r
                                               : change_elapsed_r + 1'b1;

  // Advance the state by one tick
  always_comb begin
    stable_nxt         = stable_r;
    change_active_nxt  = change_active_r;
    change_elapsed_nxt = change_elapsed_r;
    press_seen_nxt     = press_seen_r;
    held_nxt           = held_r;
    long_done_nxt      = long_done_r;
    short_flag_nxt     = short_flag_r;
    long_flag_nxt      = long_flag_r;
    got_short          = 1'b0;
    got_long           = 1'b0;

    // hold counter runs once a press has been seen
    if (press_seen_r && (held_r != '1)) begin
      held_nxt = held_r + 1'b1;
    end

    // debounce the raw level
    if (item.raw_level != stable_r) begin
      if (!change_active_r) begin
        change_active_nxt  = 1'b1;
        change_elapsed_nxt = '0;
      end else if (CMP_W'(change_inc) >= CMP_W'(regs.debounce_ticks)) begin
        stable_nxt         = item.raw_level;
        change_active_nxt  = 1'b0;
        change_elapsed_nxt = '0;
        if (item.raw_level) begin
          press_seen_nxt = 1'b1;
          held_nxt       = '0;
          long_done_nxt  = 1'b0;
        end else if (press_seen_r && !long_done_r &&
                     (CMP_W'(held_nxt) < CMP_W'(regs.short_limit_ticks))) begin
          short_flag_nxt = 1'b1;
        end
      end else begin
        change_elapsed_nxt = change_inc;
      end
    end else begin
      change_active_nxt  = 1'b0;
      change_elapsed_nxt = '0;
    end

    // fire the long press once per press
    if (stable_nxt && press_seen_nxt && !long_done_nxt &&
        (CMP_W'(held_nxt) >= CMP_W'(regs.long_hold_ticks))) begin
      long_done_nxt = 1'b1;
      long_flag_nxt = 1'b1;
    end

    // take requests consume pending flags
    if (item.take_short && short_flag_nxt) begin
      short_flag_nxt = 1'b0;
      got_short      = 1'b1;
    end
    if (item.take_long && long_flag_nxt) begin
      long_flag_nxt = 1'b0;
      got_long      = 1'b1;
    end
  end

  // Result of this tick
  always_comb begin
    result.stable_level     = stable_nxt;
    result.press_taken      = got_short;
    result.long_press_taken = got_long;
    result.short_waiting    = short_flag_nxt;
    result.long_waiting     = long_flag_nxt;
  end

  // Commit the state when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r         <= 1'b0;
      change_active_r  <= 1'b0;
      change_elapsed_r <= '0;
      press_seen_r     <= 1'b0;
      held_r           <= '0;
      long_done_r      <= 1'b0;
      short_flag_r     <= 1'b0;
      long_flag_r      <= 1'b0;
    end else if (adv) begin
      stable_r         <= stable_nxt;
      change_active_r  <= change_active_nxt;
      change_elapsed_r <= change_elapsed_nxt;
      press_seen_r     <= press_seen_nxt;
      held_r           <= held_nxt;
      long_done_r      <= long_done_nxt;
      short_flag_r     <= short_flag_nxt;
      long_flag_r      <= long_flag_nxt;
    end
  end

  // A short press is only flagged on an accepted release
  a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(short_flag_r) |-> $fell(stable_r))
    else $error("short flag rose without a release");

  // A long press flag always marks its press as done
  a_long_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(long_flag_r) |-> long_done_r)
    else $error("long flag rose without long_done");

  // The hold counter stays at zero until the first press
  a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !press_seen_r |-> (held_r == '0))
    else $error("hold counter moved before any press");

endmodule
